// ===== hdl/crc8lr_pkg.sv =====
// crc8lr_pkg: shared types, codes and helper functions for the CRC-8 framed line receiver.
// Used by crc8lr_line_fsm and crc8_framed_line_receiver; depends on nothing.
`default_nettype none

package crc8lr_pkg;

    localparam int unsigned MAX_LINE = 1024;
    // line byte count must hold MAX_LINE itself; payload count never reaches it
    localparam int unsigned LEN_W    = $clog2(MAX_LINE + 1);
    localparam int unsigned CNT_W    = $clog2(MAX_LINE);
    localparam int unsigned PLEN_W   = 10;

    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] CRC_MSB   = 8'h80;
    localparam logic [7:0] CRC_INIT  = 8'h00;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_MISMATCH = 3'd1;
    localparam t_status ST_NO_START = 3'd2;
    localparam t_status ST_NO_STAR  = 3'd3;
    localparam t_status ST_EMPTY    = 3'd4;

    typedef enum logic [2:0] {
        PH_LEADING = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_NOMARK  = 3'b100
    } t_line_phase;

    typedef enum logic [2:0] {
        HX_SKIP   = 3'b001,
        HX_GATHER = 3'b010,
        HX_DONE   = 3'b100
    } t_hex_phase;

    typedef struct packed {
        t_status           status;
        logic [7:0]        computed_crc;
        logic [7:0]        received_crc;
        logic [PLEN_W-1:0] payload_length;
    } t_result;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {["0":"9"]}) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b inside {["a":"f"]}) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b inside {["A":"F"]}) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/crc8lr_line_fsm.sv =====
// crc8lr_line_fsm: per-line parse state, running CRC-8, hex gathering and result forming.
// Depends on crc8lr_pkg.
`default_nettype none

module crc8lr_line_fsm
    import crc8lr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output t_result         o_res
);

    t_line_phase      r_line_phase, n_line_phase;
    t_hex_phase       r_hex_phase,  n_hex_phase;
    logic [LEN_W-1:0] r_line_len,   n_line_len;
    logic [CNT_W-1:0] r_pay_cnt,    n_pay_cnt;
    logic [CNT_W-1:0] r_len_at_star, n_len_at_star;
    logic [7:0]       r_crc,        n_crc;
    logic [7:0]       r_crc_at_star, n_crc_at_star;
    logic [7:0]       r_hex_acc,    n_hex_acc;
    logic             r_star_seen,  n_star_seen;

    logic             w_space;
    logic [4:0]       w_hex;

    assign w_space = is_space(i_byte);
    assign w_hex   = hex_digit(i_byte);

    always_comb begin
        n_line_phase  = r_line_phase;
        n_hex_phase   = r_hex_phase;
        n_line_len    = r_line_len;
        n_pay_cnt     = r_pay_cnt;
        n_len_at_star = r_len_at_star;
        n_crc         = r_crc;
        n_crc_at_star = r_crc_at_star;
        n_hex_acc     = r_hex_acc;
        n_star_seen   = r_star_seen;

        if (i_fire) begin
            if ((i_byte == CH_LF) || (r_line_len >= LEN_W'(MAX_LINE))) begin
                // end of line, or overlong line dropped: back to a fresh line
                n_line_phase  = PH_LEADING;
                n_hex_phase   = HX_SKIP;
                n_line_len    = '0;
                n_pay_cnt     = '0;
                n_len_at_star = '0;
                n_crc         = CRC_INIT;
                n_crc_at_star = CRC_INIT;
                n_hex_acc     = 8'h00;
                n_star_seen   = 1'b0;
            end else begin
                n_line_len = r_line_len + LEN_W'(1);
                case (r_line_phase)
                    PH_LEADING: begin
                        if (!w_space) begin
                            if (i_byte == CH_DOLLAR) begin
                                n_line_phase = PH_PAYLOAD;
                                n_crc        = CRC_INIT;
                                n_pay_cnt    = '0;
                            end else begin
                                n_line_phase = PH_NOMARK;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        if (i_byte == CH_STAR) begin
                            n_crc_at_star = r_crc;
                            n_len_at_star = r_pay_cnt;
                            n_star_seen   = 1'b1;
                            n_hex_acc     = 8'h00;
                            n_hex_phase   = HX_SKIP;
                        end else if (r_star_seen) begin
                            if ((r_hex_phase == HX_SKIP) && w_space) begin
                                n_hex_phase = r_hex_phase;
                            end else if ((r_hex_phase != HX_DONE) && w_hex[4]) begin
                                n_hex_phase = HX_GATHER;
                                n_hex_acc   = {r_hex_acc[3:0], w_hex[3:0]};
                            end else begin
                                n_hex_phase = HX_DONE;
                            end
                        end
                        n_crc     = crc8_byte(r_crc, i_byte);
                        n_pay_cnt = r_pay_cnt + CNT_W'(1);
                    end
                    default: begin
                        n_line_phase = r_line_phase;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_res = '0;
        case (r_line_phase)
            PH_LEADING: o_res.status = ST_EMPTY;
            PH_NOMARK:  o_res.status = ST_NO_START;
            default: begin
                if (!r_star_seen) begin
                    o_res.status = ST_NO_STAR;
                end else begin
                    o_res.computed_crc   = r_crc_at_star;
                    o_res.received_crc   = r_hex_acc;
                    o_res.payload_length = PLEN_W'(r_len_at_star);
                    o_res.status = (r_crc_at_star == r_hex_acc) ? ST_OK : ST_MISMATCH;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_phase  <= PH_LEADING;
            r_hex_phase   <= HX_SKIP;
            r_line_len    <= '0;
            r_pay_cnt     <= '0;
            r_len_at_star <= '0;
            r_crc         <= CRC_INIT;
            r_crc_at_star <= CRC_INIT;
            r_hex_acc     <= 8'h00;
            r_star_seen   <= 1'b0;
        end else begin
            r_line_phase  <= n_line_phase;
            r_hex_phase   <= n_hex_phase;
            r_line_len    <= n_line_len;
            r_pay_cnt     <= n_pay_cnt;
            r_len_at_star <= n_len_at_star;
            r_crc         <= n_crc;
            r_crc_at_star <= n_crc_at_star;
            r_hex_acc     <= n_hex_acc;
            r_star_seen   <= n_star_seen;
        end
    end

`ifndef NO_ASSERTIONS
    a_snap_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_star_seen |-> (r_crc_at_star == CRC_INIT) && (r_len_at_star == '0))
        else $error("star snapshot set without a star");

    a_snap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len_at_star <= r_pay_cnt)
        else $error("star length beyond payload count");

    a_hex_needs_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hex_phase != HX_SKIP) |-> r_star_seen)
        else $error("hex gathering without a star");

    a_count_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line_phase != PH_PAYLOAD) |-> (r_pay_cnt == '0) && !r_star_seen)
        else $error("payload state outside payload phase");
`endif

endmodule

`default_nettype wire

// ===== hdl/crc8_framed_line_receiver.sv =====
// Channel  | direction | handshake             | word
// ---------+-----------+-----------------------+------------------------------------------
// in       | input     | i_in_valid/o_in_stall | i_rx_byte
// out      | output    | o_out_valid/i_out_stall| o_line_status, o_computed_crc,
//          |           |                       | o_received_crc, o_payload_length
//
// One word per cycle unless a newline word waits on a full result register:
// input register, the line parser and CRC-8, and for a newline the result register.
// Synchronous active-low reset clears the line state and the valid flags of both stages.
// Out stall holds the result register; only a newline word waits behind a full result
// register, other words keep flowing.
// Top level of the CRC-8 framed line receiver. Depends on crc8lr_pkg, crc8lr_line_fsm.
`default_nettype none

module crc8_framed_line_receiver
    import crc8lr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [2:0]             o_line_status,
    output logic [7:0]             o_computed_crc,
    output logic [7:0]             o_received_crc,
    output logic [PLEN_W-1:0]      o_payload_length
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;

    logic       w_is_nl;
    logic       w_out_free;
    logic       w_fire;
    logic       w_accept;
    t_result    w_res;

    assign w_is_nl    = (r_in_byte == CH_LF);
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_fire     = r_in_vld && (!w_is_nl || w_out_free);
    assign o_in_stall = r_in_vld && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    crc8lr_line_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && w_is_nl) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_is_nl) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_line_status    = r_out.status;
    assign o_computed_crc   = r_out.computed_crc;
    assign o_received_crc   = r_out.received_crc;
    assign o_payload_length = r_out.payload_length;

endmodule

`default_nettype wire
